/* design/ccnb_token_parser_assert.svh */
// Assertion macros used by the checker file of the token parser.
`ifndef CCNB_TOKEN_PARSER_ASSERT_SVH
`define CCNB_TOKEN_PARSER_ASSERT_SVH

// Concurrent assertion sampled on clk_i and switched off while rst_ni is low.
`define CCNB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check without a reset guard, for properties that hold during reset too.
`define CCNB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/ccnbtp_pkg.sv */
// ----------------------------------------------------------------------------
// ccnbtp_pkg
// Types, codes and default sizes shared by the ccnb token parser modules.
// ----------------------------------------------------------------------------
package ccnbtp_pkg;

  localparam int MaxDepthDef    = 32;
  localparam int MaxHdrBytesDef = 4;

  localparam int ByteW  = 8;
  localparam int TypeW  = 3;
  localparam int NumW   = 25;
  localparam int AccW   = 21;
  localparam int DepthW = 6;

  // Header type codes carried in the low three bits of the final header byte.
  localparam logic [TypeW-1:0] HtExt   = 3'd0;
  localparam logic [TypeW-1:0] HtDtag  = 3'd2;
  localparam logic [TypeW-1:0] HtBlob  = 3'd5;
  localparam logic [TypeW-1:0] HtUdata = 3'd6;

  typedef enum logic [2:0] {
    EvOpen  = 3'd0,
    EvDhdr  = 3'd1,
    EvDbyte = 3'd2,
    EvClose = 3'd3,
    EvIgn   = 3'd4,
    EvEnd   = 3'd5,
    EvErr   = 3'd6
  } ev_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_data;
  } in_beat_t;

  typedef struct packed {
    ev_kind_e          event_kind;
    logic [TypeW-1:0]  header_type;
    logic [NumW-1:0]   header_number;
    logic [DepthW-1:0] nest_depth;
    logic [ByteW-1:0]  data_value;
    logic              last_data;
  } out_beat_t;

endpackage

/* design/ccnb_token_parser.sv */
// ----------------------------------------------------------------------------
// ccnb_token_parser
// Decodes ccnb binary XML bytes into open, close, data, end and error events.
// ----------------------------------------------------------------------------
// The input channel carries one byte of the encoded buffer per beat, with
// end_of_data set on the last byte of a buffer. The output channel carries at
// most one event per input beat; continuation bytes of a header and bytes
// swallowed after an error produce no event.
// An event is registered in the output buffer before it shows on out_beat_o.
// Throughput is one byte per cycle while in_stall_o is low, set by the single
// decode stage that updates the header accumulator, depth and payload counter.
// A result register plus one skid entry sit on the output, so a byte is taken
// even while an event waits; in_stall_o rises only once both are occupied.
// Reset clears the parser state and empties both output entries; no event is
// pending afterwards. A buffer's last byte returns the decode state to its reset values.
// ----------------------------------------------------------------------------
module ccnb_token_parser #(
  parameter int MAX_DEPTH        = ccnbtp_pkg::MaxDepthDef,
  parameter int MAX_HEADER_BYTES = ccnbtp_pkg::MaxHdrBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ccnbtp_pkg::in_beat_t  in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ccnbtp_pkg::out_beat_t out_beat_o
);
  import ccnbtp_pkg::*;

  logic      in_fire;
  logic      res_valid;
  out_beat_t res;
  logic      buf_full;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  ccnbtp_decode #(
    .MaxDepth   (MAX_DEPTH),
    .MaxHdrBytes(MAX_HEADER_BYTES)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_beat_i  (in_beat_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ccnbtp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_beat_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule

/* design/ccnbtp_decode.sv */
// ----------------------------------------------------------------------------
// ccnbtp_decode
// Parser state and the single-pass decode of one input byte into zero or one
// event.
// ----------------------------------------------------------------------------
module ccnbtp_decode #(
  parameter int MaxDepth    = ccnbtp_pkg::MaxDepthDef,
  parameter int MaxHdrBytes = ccnbtp_pkg::MaxHdrBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_fire_i,
  input  ccnbtp_pkg::in_beat_t  in_beat_i,
  output logic                  res_valid_o,
  output ccnbtp_pkg::out_beat_t res_o
);
  import ccnbtp_pkg::*;

  localparam int SeenW = (MaxHdrBytes > 2) ? $clog2(MaxHdrBytes) : 1;
  localparam logic [SeenW:0] HdrLimit = (SeenW + 1)'(MaxHdrBytes);
  localparam logic [DepthW-1:0] DepthLimit = DepthW'(MaxDepth);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhData   = 2'd1,
    PhHalt   = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [SeenW-1:0]  seen_q, seen_d;
  logic [NumW-1:0]   remain_q, remain_d;
  logic [DepthW-1:0] depth_q, depth_d;

  logic [ByteW-1:0]  byte_c;
  logic              eod;
  logic [NumW-1:0]   num;
  logic [TypeW-1:0]  typ;
  logic              close_hit;
  logic              err_hit;
  logic              last;

  assign byte_c = in_beat_i.in_byte;
  assign eod    = in_beat_i.end_of_data;
  assign num    = {acc_q, byte_c[6:3]};
  assign typ    = byte_c[2:0];
  assign last   = (remain_q <= NumW'(1));

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    remain_d    = remain_q;
    depth_d     = depth_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    close_hit   = 1'b0;
    err_hit     = 1'b0;

    if (in_fire_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (seen_q == '0 && byte_c == '0) begin
            close_hit = 1'b1;
          end else if (!byte_c[7]) begin
            if (({1'b0, seen_q} + 1'b1) >= HdrLimit || eod) begin
              err_hit = 1'b1;
            end else begin
              acc_d  = {acc_q[AccW-8:0], byte_c[6:0]};
              seen_d = seen_q + SeenW'(1);
            end
          end else begin
            acc_d  = '0;
            seen_d = '0;
            res_o.header_type   = typ;
            res_o.header_number = num;
            res_o.nest_depth    = depth_q;
            priority if (typ == HtExt && num == '0) begin
              close_hit = 1'b1;
            end else if (typ == HtDtag) begin
              if (depth_q >= DepthLimit) begin
                err_hit = 1'b1;
              end else begin
                res_valid_o      = 1'b1;
                res_o.event_kind = EvOpen;
                depth_d          = depth_q + 1'b1;
              end
            end else if (typ == HtBlob || typ == HtUdata) begin
              if (num != '0 && eod) begin
                err_hit = 1'b1;
              end else begin
                res_valid_o      = 1'b1;
                res_o.event_kind = EvDhdr;
                if (num != '0) begin
                  remain_d = num;
                  phase_d  = PhData;
                end
              end
            end else begin
              res_valid_o      = 1'b1;
              res_o.event_kind = EvIgn;
            end
          end
        end
        PhData: begin
          if (eod && !last) begin
            err_hit = 1'b1;
          end else begin
            remain_d = last ? '0 : remain_q - 1'b1;
            if (last) begin
              phase_d = PhHeader;
            end
            res_valid_o      = 1'b1;
            res_o.event_kind = EvDbyte;
            res_o.nest_depth = depth_q;
            res_o.data_value = byte_c;
            res_o.last_data  = last;
          end
        end
        default: begin
          // Halted: bytes are swallowed until the end of the buffer.
        end
      endcase

      if (close_hit) begin
        res_valid_o = 1'b1;
        res_o       = '0;
        if (depth_q == '0) begin
          phase_d          = PhHalt;
          res_o.event_kind = EvEnd;
        end else begin
          depth_d          = depth_q - 1'b1;
          res_o.event_kind = EvClose;
          res_o.nest_depth = depth_q - 1'b1;
        end
      end

      if (err_hit) begin
        phase_d          = PhHalt;
        acc_d            = '0;
        seen_d           = '0;
        remain_d         = '0;
        res_valid_o      = 1'b1;
        res_o            = '0;
        res_o.event_kind = EvErr;
        res_o.nest_depth = depth_q;
      end

      // The last byte of a buffer always leaves the parser as after reset.
      if (eod) begin
        phase_d  = PhHeader;
        acc_d    = '0;
        seen_d   = '0;
        remain_d = '0;
        depth_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      acc_q    <= '0;
      seen_q   <= '0;
      remain_q <= '0;
      depth_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      remain_q <= remain_d;
      depth_q  <= depth_d;
    end
  end

endmodule

/* design/ccnbtp_out_buf.sv */
// ----------------------------------------------------------------------------
// ccnbtp_out_buf
// Result register with a skid entry, so the input side keeps flowing while
// a finished event waits on a stalled receiver.
// ----------------------------------------------------------------------------
module ccnbtp_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ccnbtp_pkg::out_beat_t push_beat_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ccnbtp_pkg::out_beat_t out_beat_o
);
  import ccnbtp_pkg::*;

  logic      main_valid_q;
  logic      skid_valid_q;
  out_beat_t main_q;
  out_beat_t skid_q;
  logic      pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_beat_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // No push can arrive while the skid entry is occupied.
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (pop || !main_valid_q) begin
      main_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (pop || !main_valid_q) begin
      main_q <= push_beat_i;
    end else if (push_i) begin
      skid_q <= push_beat_i;
    end
  end

endmodule

/* design/ccnbtp_checker.sv */
// ----------------------------------------------------------------------------
// ccnbtp_checker
// Port-level checks for the ccnb token parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ccnb_token_parser_assert.svh"

module ccnbtp_checker #(
  parameter int MaxDepth = ccnbtp_pkg::MaxDepthDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input ccnbtp_pkg::in_beat_t  in_beat_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input ccnbtp_pkg::out_beat_t out_beat_o
);
  import ccnbtp_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_beat_i);

  // A waiting event must not vanish while the receiver stalls.
  `CCNB_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "event dropped under stall")

  // The input side only backs up once the output register is occupied.
  `CCNB_ASSERT_ALWAYS(a_stall_needs_out, in_stall_o |-> out_valid_o, "input stalled with empty output")

  // Payload byte events never carry header fields.
  `CCNB_ASSERT(a_dbyte_clean, out_valid_o && out_beat_o.event_kind == EvDbyte |-> out_beat_o.header_type == '0 && out_beat_o.header_number == '0, "data byte with header fields")

  // Reported depth never exceeds the configured nesting limit.
  `CCNB_ASSERT(a_depth_bound, out_valid_o |-> out_beat_o.nest_depth <= DepthW'(MaxDepth), "depth above limit")

endmodule

bind ccnb_token_parser ccnbtp_checker #(.MaxDepth(MAX_DEPTH)) u_checker (.*);

/* tb/ccnb_token_parser_test.sv */
// ----------------------------------------------------------------------------
// ccnb_token_parser_test
// Streams ccnb buffers into the token parser and checks every event it emits.
// ----------------------------------------------------------------------------
// Each accepted byte goes through a behavioral decoder in this file. The
// decoder tracks the header accumulator, payload count and nesting depth, and
// queues the event that the byte should cause. Every event beat from the
// parser is compared field by field with the oldest queued event. Directed
// buffers cover the header forms, the broken buffers and the depth limits.
// Random buffers follow: mostly well-formed nesting with random content,
// plus truncated buffers and raw noise.
// ----------------------------------------------------------------------------
module ccnb_token_parser_test;
  import ccnbtp_pkg::*;

  localparam int MaxDepth    = MaxDepthDef;
  localparam int MaxHdrBytes = MaxHdrBytesDef;
  localparam int RandBytes   = 330;

  // Header types without a name in the package; all are reported as ignored.
  localparam logic [TypeW-1:0] HtTag   = 3'd1;
  localparam logic [TypeW-1:0] HtAttr  = 3'd3;
  localparam logic [TypeW-1:0] HtDattr = 3'd4;
  localparam logic [TypeW-1:0] HtRsvd  = 3'd7;

  typedef enum logic [1:0] {
    PhHeader,
    PhData,
    PhHalt
  } parse_phase_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;

  // Decoder state.
  parse_phase_e      phase;
  logic [AccW-1:0]   hdr_acc;
  int                hdr_seen;
  logic [NumW-1:0]   pay_left;
  logic [DepthW-1:0] depth;

  out_beat_t   events_due[$];
  out_beat_t   event_want;
  logic [7:0]  stream_bytes[$];
  int          live_bytes = 0;
  int          mismatches = 0;
  bit          steady;

  logic [TypeW-1:0] ign_types[5] = '{HtExt, HtTag, HtAttr, HtDattr, HtRsvd};

  ccnb_token_parser #(
    .MAX_DEPTH       (MaxDepth),
    .MAX_HEADER_BYTES(MaxHdrBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("ccnb_token_parser_test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 27);
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_decoder();
    phase    = PhHeader;
    hdr_acc  = '0;
    hdr_seen = 0;
    pay_left = '0;
    depth    = '0;
  endtask

  function automatic out_beat_t close_event();
    out_beat_t ev;
    ev = '0;
    if (depth == 0) begin
      phase = PhHalt;
      ev.event_kind = EvEnd;
    end else begin
      depth--;
      ev.event_kind = EvClose;
      ev.nest_depth = depth;
    end
    return ev;
  endfunction

  function automatic out_beat_t error_event();
    out_beat_t ev;
    ev = '0;
    phase    = PhHalt;
    hdr_acc  = '0;
    hdr_seen = 0;
    pay_left = '0;
    ev.event_kind = EvErr;
    ev.nest_depth = depth;
    return ev;
  endfunction

  // Works out the event caused by one accepted byte and advances the state.
  task automatic decode_byte(input in_beat_t b);
    out_beat_t        ev;
    bit               fire;
    bit               eod;
    bit               last;
    logic [NumW-1:0]  num;
    logic [TypeW-1:0] typ;
    ev   = '0;
    fire = (phase == PhHeader || phase == PhData);
    eod  = b.end_of_data;
    last = (pay_left <= 1);
    num  = {hdr_acc, b.in_byte[6:3]};
    typ  = b.in_byte[2:0];
    if (fire) live_bytes++;
    case (phase)
      PhHeader: begin
        if (hdr_seen == 0 && b.in_byte == 8'h00) begin
          ev = close_event();
        end else if (!b.in_byte[7]) begin
          if (hdr_seen + 1 >= MaxHdrBytes || eod) begin
            ev = error_event();
          end else begin
            hdr_acc = {hdr_acc[AccW-8:0], b.in_byte[6:0]};
            hdr_seen++;
            fire = 1'b0;
          end
        end else begin
          hdr_acc  = '0;
          hdr_seen = 0;
          ev.header_type   = typ;
          ev.header_number = num;
          ev.nest_depth    = depth;
          if (typ == HtExt && num == 0) begin
            ev = close_event();
          end else if (typ == HtDtag) begin
            if (depth >= MaxDepth) begin
              ev = error_event();
            end else begin
              ev.event_kind = EvOpen;
              depth++;
            end
          end else if (typ == HtBlob || typ == HtUdata) begin
            if (num != 0 && eod) begin
              ev = error_event();
            end else begin
              ev.event_kind = EvDhdr;
              if (num != 0) begin
                pay_left = num;
                phase    = PhData;
              end
            end
          end else begin
            ev.event_kind = EvIgn;
          end
        end
      end
      PhData: begin
        if (eod && !last) begin
          ev = error_event();
        end else begin
          ev.event_kind = EvDbyte;
          ev.nest_depth = depth;
          ev.data_value = b.in_byte;
          ev.last_data  = last;
          pay_left = last ? '0 : pay_left - 1'b1;
          if (last) phase = PhHeader;
        end
      end
      default: ;
    endcase
    if (fire) events_due.push_back(ev);
    if (eod) clear_decoder();
  endtask

  // Output beats are checked before the input beat of the same edge is decoded.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (events_due.size() == 0) begin
          report_mismatch($sformatf("event with nothing pending: %p", out_beat_o));
        end else begin
          event_want = events_due.pop_front();
          if (out_beat_o.event_kind !== event_want.event_kind)
            report_mismatch($sformatf("event_kind %0d, want %0d",
                                      out_beat_o.event_kind, event_want.event_kind));
          if (out_beat_o.header_type !== event_want.header_type)
            report_mismatch($sformatf("header_type %0d, want %0d",
                                      out_beat_o.header_type, event_want.header_type));
          if (out_beat_o.header_number !== event_want.header_number)
            report_mismatch($sformatf("header_number %0h, want %0h",
                                      out_beat_o.header_number, event_want.header_number));
          if (out_beat_o.nest_depth !== event_want.nest_depth)
            report_mismatch($sformatf("nest_depth %0d, want %0d",
                                      out_beat_o.nest_depth, event_want.nest_depth));
          if (out_beat_o.data_value !== event_want.data_value)
            report_mismatch($sformatf("data_value %0h, want %0h",
                                      out_beat_o.data_value, event_want.data_value));
          if (out_beat_o.last_data !== event_want.last_data)
            report_mismatch($sformatf("last_data %0b, want %0b",
                                      out_beat_o.last_data, event_want.last_data));
        end
      end
      if (in_valid_i && !in_stall_o) decode_byte(in_beat_i);
    end else begin
      clear_decoder();
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic eod);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= '{in_byte: value, end_of_data: eod};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sends the staged bytes as one buffer, end_of_data on the last one.
  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++) begin
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    end
    stream_bytes.delete();
  endtask

  // Continuation bytes carry the number above its low four bits, seven bits
  // each, leading zero groups left out so that no header starts with a zero.
  task automatic put_header(input logic [NumW-1:0] num, input logic [TypeW-1:0] typ);
    logic [AccW-1:0] hi;
    bit              started;
    hi      = num[NumW-1:4];
    started = 1'b0;
    for (int k = 2; k >= 0; k--) begin
      if (started || hi[7*k +: 7] != 0) begin
        stream_bytes.push_back({1'b0, hi[7*k +: 7]});
        started = 1'b1;
      end
    end
    stream_bytes.push_back({1'b1, num[3:0], typ});
  endtask

  task automatic put_close();
    if ($urandom_range(1)) stream_bytes.push_back(8'h00);
    else put_header('0, HtExt);
  endtask

  function automatic logic [NumW-1:0] pick_number();
    int r;
    r = $urandom_range(9);
    if (r < 5) return NumW'($urandom_range(15));
    if (r < 8) return NumW'($urandom_range(2047));
    return NumW'($urandom());
  endfunction

  // Stages a well-formed buffer: nested opens and closes, payloads and
  // ignored headers, usually closed back to depth zero.
  task automatic build_stream();
    int               level;
    int               count;
    int               len;
    logic [TypeW-1:0] typ;
    logic [NumW-1:0]  num;
    level = 0;
    count = $urandom_range(1, 20);
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          if (level < MaxDepth) begin
            put_header(pick_number(), HtDtag);
            level++;
          end else begin
            put_close();
            level--;
          end
        end
        3, 4: begin
          if (level > 0) begin
            put_close();
            level--;
          end else begin
            put_header(pick_number() | 1'b1, HtTag);
          end
        end
        5, 6: begin
          typ = $urandom_range(1) ? HtBlob : HtUdata;
          len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
          put_header(NumW'(len), typ);
          repeat (len) stream_bytes.push_back(8'($urandom_range(255)));
        end
        default: begin
          typ = ign_types[$urandom_range(4)];
          num = pick_number();
          if (typ == HtExt && num == 0) num = 1;
          put_header(num, typ);
        end
      endcase
    end
    if ($urandom_range(3) != 0) begin
      while (level > 0) begin
        put_close();
        level--;
      end
      if ($urandom_range(1)) stream_bytes.push_back(8'h00);
    end
  endtask

  task automatic wait_quiet();
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_header_forms();
    put_header(25'd15, HtDtag);
    put_header(25'd3, HtBlob);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h5a);
    put_header('0, HtUdata);
    put_header(25'd1, HtExt);
    put_header(25'd9, HtTag);
    put_header(25'd6, HtAttr);
    put_header(25'd12, HtDattr);
    put_header(25'h1ffffff, HtRsvd);
    put_header('0, HtExt);
    // End at depth zero, then the parser swallows the rest of the buffer.
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h12);
    stream_bytes.push_back(8'h34);
    send_stream();
  endtask

  task automatic test_broken_buffers();
    // Too many continuation bytes.
    stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h55};
    send_stream();
    // Buffer ends inside a header.
    stream_bytes = '{8'h7f};
    send_stream();
    // Buffer ends on a header that announces a payload.
    put_header(25'd2, HtBlob);
    send_stream();
    // Buffer ends before the payload is complete.
    put_header(25'd2, HtUdata);
    stream_bytes.push_back(8'haa);
    send_stream();
  endtask

  task automatic test_depth_extremes();
    repeat (MaxDepth) put_header(pick_number(), HtDtag);
    repeat (MaxDepth) put_close();
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hff);
    send_stream();
    // One open too many at full depth.
    repeat (MaxDepth + 1) put_header(pick_number(), HtDtag);
    stream_bytes.push_back(8'h00);
    send_stream();
  endtask

  task automatic test_random_streams();
    int start;
    int r;
    start = live_bytes;
    while (live_bytes - start < RandBytes) begin
      steady = (live_bytes - start >= 200) && (live_bytes - start < 320);
      r = $urandom_range(99);
      if (r < 70) begin
        build_stream();
      end else if (r < 85) begin
        build_stream();
        stream_bytes = stream_bytes[0:$urandom_range(stream_bytes.size() - 1)];
      end else begin
        repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(255)));
      end
      send_stream();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    steady      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_forms();
    test_broken_buffers();
    test_depth_extremes();
    test_random_streams();

    in_valid_i <= 1'b0;
    wait_quiet();
    if (mismatches == 0) begin
      $display("ccnb_token_parser_test passed");
    end else begin
      $display("ccnb_token_parser_test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ccnbtp_pkg.sv
design/ccnbtp_decode.sv
design/ccnbtp_out_buf.sv
design/ccnb_token_parser.sv
design/ccnbtp_checker.sv
tb/ccnb_token_parser_test.sv
